/* rtl/bma_pkg.sv */
// ----------------------------------------------------------------------------
// bma_pkg: shared constants for the boxcar moving average
// Window size, field widths and the stream word widths used by the block.
// ----------------------------------------------------------------------------
package bma_pkg;

    // The window holds 2^WINDOW_LOG2 samples.
    localparam int WINDOW_LOG2 = 4;
    localparam int WIN_SIZE    = 1 << WINDOW_LOG2;

    // Field widths.
    localparam int RAW_W    = 16;
    localparam int SAMPLE_W = 12;
    localparam int AVG_W    = 12;
    localparam int SUM_W    = SAMPLE_W + WINDOW_LOG2;
    localparam int CNT_W    = WINDOW_LOG2 + 1;
    localparam int IDX_W    = WINDOW_LOG2;

    // Stream words are padded to whole bytes.
    localparam int S_DATA_W = ((RAW_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((AVG_W + 7) / 8) * 8;

    // Step counter of the warm-up divider, one quotient bit a step.
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

endpackage

/* rtl/boxcar_moving_average.sv */
// ----------------------------------------------------------------------------
// boxcar_moving_average: running mean over the last 2^WINDOW_LOG2 samples
// Ring of samples in a synchronous RAM, running sum and a serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream (s_tvalid/s_tready/s_tdata) carries one raw sample per
//   word; only its low 12 bits are used. The output stream
//   (m_tvalid/m_tready/m_tdata) carries one average per input word.
//   Once the window is full an item first reads the oldest sample from the
//   ring RAM, then updates the sum and writes the new sample back, then
//   hands the result to the output register. During warm-up the mean is
//   sum / count, worked out by a restoring divider one quotient bit a
//   cycle. s_tready is high only while no item is in work.
//   The output register holds a finished average while the receiver
//   stalls; the block still accepts and works a new item but holds its
//   result until that word is gone. After reset the sum, fill count and
//   oldest index are zero and the output is empty; the ring needs no
//   clearing as every entry is written during warm-up before it is read.
// ----------------------------------------------------------------------------
module boxcar_moving_average (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bma_pkg::S_DATA_W-1:0]  s_tdata,   // [15:0] raw_sample
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bma_pkg::M_DATA_W-1:0]  m_tdata    // [11:0] average, zero padded
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [bma_pkg::CNT_W-1:0] WIN_FULL = bma_pkg::CNT_W'(bma_pkg::WIN_SIZE);
    localparam logic [bma_pkg::DIV_CNT_W-1:0] DIV_LAST =
        bma_pkg::DIV_CNT_W'(bma_pkg::DIV_STEPS - 1);

    // Control and datapath registers.
    logic [1:0]                     state_reg, state_next;
    logic [bma_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [bma_pkg::CNT_W-1:0]      fill_reg, fill_next;
    logic [bma_pkg::IDX_W-1:0]      oldest_reg, oldest_next;
    logic [bma_pkg::SAMPLE_W-1:0]   sample_reg, sample_next;
    logic [bma_pkg::SUM_W-1:0]      dq_reg, dq_next;
    logic [bma_pkg::CNT_W-1:0]      rem_reg, rem_next;
    logic [bma_pkg::CNT_W-1:0]      divisor_reg, divisor_next;
    logic [bma_pkg::DIV_CNT_W-1:0]  step_reg, step_next;
    logic [bma_pkg::AVG_W-1:0]      result_reg, result_next;
    logic                           out_valid_reg, out_valid_next;
    logic [bma_pkg::AVG_W-1:0]      out_data_reg, out_data_next;

    // Ring RAM ports.
    logic [bma_pkg::SAMPLE_W-1:0]   ring_mem [bma_pkg::WIN_SIZE];
    logic [bma_pkg::SAMPLE_W-1:0]   ring_rdata_reg;
    logic                           ring_re;
    logic                           ring_we;
    logic [bma_pkg::IDX_W-1:0]      ring_waddr;

    // Helpers.
    logic                           s_accept;
    logic                           out_free;
    logic                           win_full;
    logic [bma_pkg::SUM_W-1:0]      sum_upd;
    logic [bma_pkg::CNT_W:0]        rem_shift;
    logic [bma_pkg::CNT_W:0]        rem_sub;
    logic                           div_ge;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign win_full = (fill_reg == WIN_FULL);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = bma_pkg::M_DATA_W'(out_data_reg);

    // The oldest sample is read as the word is accepted.
    assign ring_re    = s_accept;
    assign ring_we    = (state_reg == ST_READ);
    assign ring_waddr = win_full ? oldest_reg : fill_reg[bma_pkg::IDX_W-1:0];

    // New running sum: the oldest sample leaves once the window is full.
    always_comb begin
        if (win_full) begin
            sum_upd = sum_reg - bma_pkg::SUM_W'(ring_rdata_reg)
                              + bma_pkg::SUM_W'(sample_reg);
        end else begin
            sum_upd = sum_reg + bma_pkg::SUM_W'(sample_reg);
        end
    end

    // One restoring division step.
    assign rem_shift = {rem_reg, dq_reg[bma_pkg::SUM_W-1]};
    assign div_ge    = (rem_shift >= {1'b0, divisor_reg});
    assign rem_sub   = rem_shift - {1'b0, divisor_reg};

    // Sequencer and next-state logic.
    always_comb begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        fill_next      = fill_reg;
        oldest_next    = oldest_reg;
        sample_next    = sample_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;
        step_next      = step_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // The output word leaves when taken.
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    sample_next = s_tdata[bma_pkg::SAMPLE_W-1:0];
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                sum_next = sum_upd;
                if (win_full) begin
                    oldest_next = oldest_reg + 1'b1;
                    result_next = sum_upd[bma_pkg::SUM_W-1:bma_pkg::WINDOW_LOG2];
                    state_next  = ST_DONE;
                end else begin
                    fill_next    = fill_reg + 1'b1;
                    divisor_next = fill_reg + 1'b1;
                    dq_next      = sum_upd;
                    rem_next     = '0;
                    step_next    = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_ge) begin
                    rem_next = rem_sub[bma_pkg::CNT_W-1:0];
                end else begin
                    rem_next = rem_shift[bma_pkg::CNT_W-1:0];
                end
                dq_next   = {dq_reg[bma_pkg::SUM_W-2:0], div_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_LAST) begin
                    result_next = dq_next[bma_pkg::AVG_W-1:0];
                    state_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = result_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Ring RAM: one write and one registered read port.
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= sample_reg;
        end
        if (ring_re) begin
            ring_rdata_reg <= ring_mem[oldest_reg];
        end
    end

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            fill_reg      <= '0;
            oldest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            fill_reg      <= fill_next;
            oldest_reg    <= oldest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        sample_reg   <= sample_next;
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        divisor_reg  <= divisor_next;
        step_reg     <= step_next;
        result_reg   <= result_next;
        out_data_reg <= out_data_next;
    end

endmodule
